@@ design/pslt_pkg.sv @@
// Shared types and constants for the per-adapter sequence loss tracker.
package pslt_pkg;

  localparam int ADAPTERS_DEF = 8;
  localparam int WINDOW_DEF   = 256;

  localparam int KIND_W       = 1;
  localparam int ADAPTER_W    = 3;
  localparam int SEQ_W        = 32;
  localparam int EVENT_W      = 3;
  localparam int COUNT_W      = 32;
  localparam int DIST_W       = 9;

  localparam logic [DIST_W-1:0] REANCHOR_RESET = 9'd64;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 1'b1;

  typedef enum logic [EVENT_W-1:0] {
    EV_FIRST    = 3'd0,
    EV_ADVANCE  = 3'd1,
    EV_REANCHOR = 3'd2,
    EV_LATE     = 3'd3,
    EV_IGNORED  = 3'd4,
    EV_CLEARED  = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_READ     = 2'd1,
    ST_CLASSIFY = 2'd2,
    ST_UPDATE   = 2'd3
  } state_e;

  typedef struct packed {
    logic capture;
    logic read;
    logic classify;
    logic update;
  } ctrl_t;

endpackage

@@ design/per_adapter_seq_loss_tracker.sv @@
// Per-adapter sequence loss tracker: top level joining controller and datapath.
// Each accepted transaction steps through record read, classify and update in that
//   order, and update waits while the previous result is still held.
// A new transaction is accepted only once the previous one has left the update state,
//   so transactions on the per-adapter record RAM do not overlap.
// Reset: all adapters unseen, all statistics zero, reanchor distance 64; no clearing pass.
module per_adapter_seq_loss_tracker #(
  parameter int ADAPTERS = pslt_pkg::ADAPTERS_DEF,
  parameter int WINDOW   = pslt_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pslt_pkg::DIST_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pslt_pkg::KIND_W-1:0]      kind_i,
  input  logic [pslt_pkg::ADAPTER_W-1:0]   adapter_i,
  input  logic [pslt_pkg::SEQ_W-1:0]       seq_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pslt_pkg::EVENT_W-1:0]     event_res_o,
  output logic [pslt_pkg::COUNT_W-1:0]     expected_count_o,
  output logic [pslt_pkg::COUNT_W-1:0]     received_count_o
);

  pslt_pkg::ctrl_t cmd;

  pslt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pslt_dp #(
    .ADAPTERS (ADAPTERS),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .adapter_i        (adapter_i),
    .seq_i            (seq_i),
    .event_res_o      (event_res_o),
    .expected_count_o (expected_count_o),
    .received_count_o (received_count_o)
  );

endmodule

@@ design/pslt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pslt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pslt_ctrl.sv @@
// Controller state machine: sequences read, classify and update for one transaction.
module pslt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pslt_pkg::ctrl_t cmd_o
);

  pslt_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pslt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pslt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pslt_pkg::ST_READ;
        end
      end
      pslt_pkg::ST_READ:     state_d = pslt_pkg::ST_CLASSIFY;
      pslt_pkg::ST_CLASSIFY: state_d = pslt_pkg::ST_UPDATE;
      pslt_pkg::ST_UPDATE: begin
        if (slot_free) begin
          state_d = pslt_pkg::ST_IDLE;
        end
      end
      default: state_d = pslt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      pslt_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      pslt_pkg::ST_READ:     cmd_o.read = 1'b1;
      pslt_pkg::ST_CLASSIFY: cmd_o.classify = 1'b1;
      pslt_pkg::ST_UPDATE: begin
        // hold the result until the output register can take it
        if (slot_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/pslt_dp.sv @@
// Datapath: per-adapter record store, classification and window/counter update.
module pslt_dp #(
  parameter int ADAPTERS = pslt_pkg::ADAPTERS_DEF,
  parameter int WINDOW   = pslt_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pslt_pkg::ctrl_t                  cmd_i,
  input  logic                             cfg_we_i,
  input  logic [pslt_pkg::DIST_W-1:0]      cfg_wdata_i,
  input  logic [pslt_pkg::KIND_W-1:0]      kind_i,
  input  logic [pslt_pkg::ADAPTER_W-1:0]   adapter_i,
  input  logic [pslt_pkg::SEQ_W-1:0]       seq_i,
  output logic [pslt_pkg::EVENT_W-1:0]     event_res_o,
  output logic [pslt_pkg::COUNT_W-1:0]     expected_count_o,
  output logic [pslt_pkg::COUNT_W-1:0]     received_count_o
);

  localparam int AW = (ADAPTERS > 1) ? $clog2(ADAPTERS) : 1;
  localparam int WW = $clog2(WINDOW);
  localparam int SW = pslt_pkg::SEQ_W;
  localparam int CW = pslt_pkg::COUNT_W;
  localparam int DW = pslt_pkg::DIST_W;
  localparam int RW = SW + WINDOW + CW + CW;
  localparam int XW = 9;

  // captured transaction
  logic [pslt_pkg::KIND_W-1:0]    kind_q;
  logic [pslt_pkg::ADAPTER_W-1:0] adapter_q;
  logic [SW-1:0]                  seq_q;

  logic [DW-1:0]       reanchor_q;
  logic [ADAPTERS-1:0] seen_q;
  logic [ADAPTERS-1:0] stats_vld_q;

  logic [XW-1:0] adapter_ext;
  logic          in_range;
  logic [AW-1:0] idx;

  logic [RW-1:0]     rd_data;
  logic [SW-1:0]     rd_hi;
  logic [WINDOW-1:0] rd_map;
  logic [CW-1:0]     rd_exp;
  logic [CW-1:0]     rd_rcv;

  logic              seen_cur;
  logic              stat_ok;
  logic [WINDOW-1:0] cur_map;
  logic [CW-1:0]     cur_exp;
  logic [CW-1:0]     cur_rcv;

  logic [SW-1:0] up_delta;
  logic [SW-1:0] dn_delta;
  logic [SW-1:0] dn_idx;
  logic          seq_gt;
  logic          late_hit;

  pslt_pkg::event_e ev_d, ev_q;
  logic [DW-1:0]    delta_q;
  logic [WW-1:0]    lidx_q;

  logic [SW-1:0]     new_hi;
  logic [WINDOW-1:0] new_map;
  logic [CW-1:0]     new_exp;
  logic [CW-1:0]     new_rcv;
  logic [WINDOW-1:0] fill_mask;
  logic              wr_en;

  pslt_pkg::event_e ev_out_q;
  logic [CW-1:0]    exp_out_q;
  logic [CW-1:0]    rcv_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_i;
      adapter_q <= adapter_i;
      seq_q     <= seq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reanchor_q <= pslt_pkg::REANCHOR_RESET;
    end else if (cfg_we_i) begin
      reanchor_q <= cfg_wdata_i;
    end
  end

  assign adapter_ext = XW'(adapter_q);
  assign in_range    = adapter_ext < XW'(ADAPTERS);
  assign idx         = AW'(adapter_ext);

  pslt_ram #(
    .WIDTH (RW),
    .DEPTH (ADAPTERS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx),
    .wdata_i ({new_hi, new_map, new_exp, new_rcv}),
    .re_i    (cmd_i.read),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  assign rd_hi  = rd_data[RW-1 -: SW];
  assign rd_map = rd_data[CW+CW +: WINDOW];
  assign rd_exp = rd_data[CW +: CW];
  assign rd_rcv = rd_data[0 +: CW];

  // stats of an adapter not written since the last clear read as zero
  assign seen_cur = in_range && seen_q[idx];
  assign stat_ok  = in_range && stats_vld_q[idx];
  assign cur_map  = stat_ok ? rd_map : '0;
  assign cur_exp  = stat_ok ? rd_exp : '0;
  assign cur_rcv  = stat_ok ? rd_rcv : '0;

  assign seq_gt   = seq_q > rd_hi;
  assign up_delta = seq_q - rd_hi;
  assign dn_delta = rd_hi - seq_q;
  assign dn_idx   = dn_delta - SW'(1);
  assign late_hit = (dn_delta != '0) && (dn_idx < SW'(WINDOW)) && cur_map[dn_idx[WW-1:0]];

  always_comb begin
    if (kind_q == pslt_pkg::KIND_CLEAR) begin
      ev_d = pslt_pkg::EV_CLEARED;
    end else if (!in_range) begin
      ev_d = pslt_pkg::EV_IGNORED;
    end else if (!seen_cur) begin
      ev_d = pslt_pkg::EV_FIRST;
    end else if (seq_gt) begin
      ev_d = (up_delta > SW'(reanchor_q)) ? pslt_pkg::EV_REANCHOR : pslt_pkg::EV_ADVANCE;
    end else if (late_hit) begin
      ev_d = pslt_pkg::EV_LATE;
    end else begin
      ev_d = pslt_pkg::EV_IGNORED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      ev_q    <= ev_d;
      delta_q <= up_delta[DW-1:0];
      lidx_q  <= dn_idx[WW-1:0];
    end
  end

  // skipped numbers below the new highest: bits 0 .. delta-2
  assign fill_mask = ~({WINDOW{1'b1}} << (delta_q - DW'(1)));

  always_comb begin
    new_hi  = rd_hi;
    new_map = cur_map;
    new_exp = cur_exp;
    new_rcv = cur_rcv;
    wr_en   = 1'b0;
    case (ev_q)
      pslt_pkg::EV_FIRST: begin
        new_hi  = seq_q;
        new_exp = cur_exp + CW'(1);
        new_rcv = cur_rcv + CW'(1);
        wr_en   = cmd_i.update;
      end
      pslt_pkg::EV_ADVANCE: begin
        new_hi  = seq_q;
        new_map = (cur_map << delta_q) | fill_mask;
        new_exp = cur_exp + CW'(delta_q);
        new_rcv = cur_rcv + CW'(1);
        wr_en   = cmd_i.update;
      end
      pslt_pkg::EV_REANCHOR: begin
        new_hi  = seq_q;
        new_map = '0;
        new_exp = cur_exp + CW'(1);
        new_rcv = cur_rcv + CW'(1);
        wr_en   = cmd_i.update;
      end
      pslt_pkg::EV_LATE: begin
        new_map         = cur_map;
        new_map[lidx_q] = 1'b0;
        new_rcv         = cur_rcv + CW'(1);
        wr_en           = cmd_i.update;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      stats_vld_q <= '0;
    end else if (cmd_i.update) begin
      if (ev_q == pslt_pkg::EV_CLEARED) begin
        stats_vld_q <= '0;
      end else if (wr_en) begin
        seen_q[idx]      <= 1'b1;
        stats_vld_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ev_out_q <= ev_q;
      if (ev_q == pslt_pkg::EV_CLEARED || !in_range) begin
        exp_out_q <= '0;
        rcv_out_q <= '0;
      end else begin
        exp_out_q <= new_exp;
        rcv_out_q <= new_rcv;
      end
    end
  end

  assign event_res_o      = ev_out_q;
  assign expected_count_o = exp_out_q;
  assign received_count_o = rcv_out_q;

`ifndef SYNTH
  a_stats_need_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stats_vld_q & ~seen_q) == '0)
    else $error("stats valid for an adapter never seen");

  a_clear_drops_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && ev_q == pslt_pkg::EV_CLEARED |=> stats_vld_q == '0)
    else $error("clear left stats valid");

  a_first_counts_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && ev_q == pslt_pkg::EV_FIRST |=> exp_out_q == CW'(1) && rcv_out_q == CW'(1))
    else $error("first packet did not report one expected and one received");
`endif

endmodule

@@ dv/tb_per_adapter_seq_loss_tracker.sv @@
// Testbench for the per-adapter sequence loss tracker: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module tb_per_adapter_seq_loss_tracker;

  localparam int NUM_ADAPTERS = pslt_pkg::ADAPTERS_DEF;
  localparam int MAP_BITS     = pslt_pkg::WINDOW_DEF;
  localparam int DIR_ROWS     = 26;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 216;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [pslt_pkg::KIND_W-1:0] KIND_NOTE = 1'b0;

  typedef struct packed {
    pslt_pkg::event_e             ev;
    logic [pslt_pkg::COUNT_W-1:0] expc;
    logic [pslt_pkg::COUNT_W-1:0] rcvc;
  } tally_t;

  typedef struct packed {
    logic [pslt_pkg::KIND_W-1:0]    kind;
    logic [pslt_pkg::ADAPTER_W-1:0] adapter;
    logic [pslt_pkg::SEQ_W-1:0]     seq;
    logic                           typed;
    tally_t                         want;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [pslt_pkg::DIST_W-1:0]    cfg_wdata  = '0;
  logic                           in_valid   = 1'b0;
  logic                           in_ready;
  logic [pslt_pkg::KIND_W-1:0]    kind       = KIND_NOTE;
  logic [pslt_pkg::ADAPTER_W-1:0] adapter    = '0;
  logic [pslt_pkg::SEQ_W-1:0]     seq        = '0;
  logic                           out_valid;
  logic                           out_ready  = 1'b0;
  logic [pslt_pkg::EVENT_W-1:0]   event_res;
  logic [pslt_pkg::COUNT_W-1:0]   expected_count;
  logic [pslt_pkg::COUNT_W-1:0]   received_count;

  // tracker state mirrored on the testbench side
  logic                           seen_q    [NUM_ADAPTERS];
  logic [pslt_pkg::SEQ_W-1:0]     top_seq   [NUM_ADAPTERS];
  logic [MAP_BITS-1:0]            gap_map   [NUM_ADAPTERS];
  logic [pslt_pkg::COUNT_W-1:0]   exp_tot   [NUM_ADAPTERS];
  logic [pslt_pkg::COUNT_W-1:0]   rcv_tot   [NUM_ADAPTERS];
  logic [pslt_pkg::DIST_W-1:0]    reanchor_dist;

  tally_t tally_q[$];
  int     mismatch_cnt   = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_NOTE, 3'd0, 32'd0,         1'b1, '{pslt_pkg::EV_FIRST,    32'd1,  32'd1}},
    '{KIND_NOTE, 3'd0, 32'd0,         1'b1, '{pslt_pkg::EV_IGNORED,  32'd1,  32'd1}},
    '{KIND_NOTE, 3'd0, 32'd5,         1'b1, '{pslt_pkg::EV_ADVANCE,  32'd6,  32'd2}},
    '{KIND_NOTE, 3'd0, 32'd3,         1'b1, '{pslt_pkg::EV_LATE,     32'd6,  32'd3}},
    '{KIND_NOTE, 3'd0, 32'd3,         1'b1, '{pslt_pkg::EV_IGNORED,  32'd6,  32'd3}},
    '{KIND_NOTE, 3'd0, 32'd69,        1'b1, '{pslt_pkg::EV_ADVANCE,  32'd70, 32'd4}},
    '{KIND_NOTE, 3'd0, 32'd134,       1'b1, '{pslt_pkg::EV_REANCHOR, 32'd71, 32'd5}},
    '{KIND_NOTE, 3'd1, 32'hFFFF_FFFF, 1'b1, '{pslt_pkg::EV_FIRST,    32'd1,  32'd1}},
    '{KIND_NOTE, 3'd1, 32'd0,         1'b1, '{pslt_pkg::EV_IGNORED,  32'd1,  32'd1}},
    '{KIND_NOTE, 3'd7, 32'hFFFF_FF00, 1'b1, '{pslt_pkg::EV_FIRST,    32'd1,  32'd1}},
    '{KIND_NOTE, 3'd7, 32'hFFFF_FFFF, 1'b1, '{pslt_pkg::EV_REANCHOR, 32'd2,  32'd2}},
    '{KIND_NOTE, 3'd2, 32'd100,       1'b1, '{pslt_pkg::EV_FIRST,    32'd1,  32'd1}},
    '{KIND_NOTE, 3'd2, 32'd164,       1'b1, '{pslt_pkg::EV_ADVANCE,  32'd65, 32'd2}},
    '{KIND_NOTE, 3'd2, 32'd101,       1'b1, '{pslt_pkg::EV_LATE,     32'd65, 32'd3}},
    '{KIND_NOTE, 3'd2, 32'd100,       1'b1, '{pslt_pkg::EV_IGNORED,  32'd65, 32'd3}},
    '{pslt_pkg::KIND_CLEAR, 3'd2, 32'hA5A5_A5A5,
      1'b1, '{pslt_pkg::EV_CLEARED, 32'd0, 32'd0}},
    '{KIND_NOTE, 3'd2, 32'd165,       1'b1, '{pslt_pkg::EV_ADVANCE,  32'd1,  32'd1}},
    '{KIND_NOTE, 3'd2, 32'd101,       1'b1, '{pslt_pkg::EV_IGNORED,  32'd1,  32'd1}},
    // walk adapter 3 forward so early marks slide out of the window
    '{KIND_NOTE, 3'd3, 32'd1000,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}},
    '{KIND_NOTE, 3'd3, 32'd1064,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}},
    '{KIND_NOTE, 3'd3, 32'd1128,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}},
    '{KIND_NOTE, 3'd3, 32'd1192,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}},
    '{KIND_NOTE, 3'd3, 32'd1256,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}},
    '{KIND_NOTE, 3'd3, 32'd1320,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}},
    '{KIND_NOTE, 3'd3, 32'd1065,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}},
    '{KIND_NOTE, 3'd3, 32'd1063,      1'b0, '{pslt_pkg::EV_IGNORED,  32'd0,  32'd0}}
  };

  logic [pslt_pkg::DIST_W-1:0] phase_dist [PHASES] = '{9'd200, 9'd1, 9'd256, 9'd0,
                                                       9'd511, 9'd37, 9'd128, 9'd64};

  per_adapter_seq_loss_tracker u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .adapter_i        (adapter),
    .seq_i            (seq),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .event_res_o      (event_res),
    .expected_count_o (expected_count),
    .received_count_o (received_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic note_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  function automatic void clear_stats();
    for (int i = 0; i < NUM_ADAPTERS; i++) begin
      gap_map[i] = '0;
      exp_tot[i] = '0;
      rcv_tot[i] = '0;
    end
  endfunction

  // Apply one transaction to the mirrored state and return the tally it reports.
  function automatic tally_t apply_packet(input logic [pslt_pkg::KIND_W-1:0] k,
                                          input logic [pslt_pkg::ADAPTER_W-1:0] a,
                                          input logic [pslt_pkg::SEQ_W-1:0] s);
    tally_t              res;
    logic [31:0]         delta;
    logic [MAP_BITS-1:0] fill;
    res.ev = pslt_pkg::EV_IGNORED;
    if (k == pslt_pkg::KIND_CLEAR) begin
      clear_stats();
      res.ev = pslt_pkg::EV_CLEARED;
    end else if (!seen_q[a]) begin
      seen_q[a]  = 1'b1;
      top_seq[a] = s;
      exp_tot[a] = exp_tot[a] + 1;
      rcv_tot[a] = rcv_tot[a] + 1;
      res.ev     = pslt_pkg::EV_FIRST;
    end else if (s > top_seq[a]) begin
      delta = s - top_seq[a];
      if (delta > {23'd0, reanchor_dist}) begin
        top_seq[a] = s;
        gap_map[a] = '0;
        exp_tot[a] = exp_tot[a] + 1;
        rcv_tot[a] = rcv_tot[a] + 1;
        res.ev     = pslt_pkg::EV_REANCHOR;
      end else begin
        if (delta - 1 >= MAP_BITS) fill = '1;
        else fill = (MAP_BITS'(1) << (delta - 1)) - MAP_BITS'(1);
        gap_map[a] = (delta >= MAP_BITS) ? '0 : (gap_map[a] << delta);
        gap_map[a] = gap_map[a] | fill;
        exp_tot[a] = exp_tot[a] + delta;
        rcv_tot[a] = rcv_tot[a] + 1;
        top_seq[a] = s;
        res.ev     = pslt_pkg::EV_ADVANCE;
      end
    end else begin
      delta = top_seq[a] - s;
      if (delta >= 1 && delta - 1 < MAP_BITS && gap_map[a][delta-1]) begin
        gap_map[a][delta-1] = 1'b0;
        rcv_tot[a] = rcv_tot[a] + 1;
        res.ev     = pslt_pkg::EV_LATE;
      end
    end
    res.expc = exp_tot[a];
    res.rcvc = rcv_tot[a];
    return res;
  endfunction

  // Mostly plausible sequence traffic for one adapter, with some noise mixed in.
  function automatic logic [pslt_pkg::SEQ_W-1:0] pick_seq(
      input logic [pslt_pkg::ADAPTER_W-1:0] a);
    int          roll;
    int          span;
    int          start;
    int          hit;
    int          idx;
    logic [31:0] s;
    roll  = $urandom_range(99);
    span  = (reanchor_dist == 0) ? 8 : int'(reanchor_dist);
    start = $urandom_range(MAP_BITS - 1);
    hit   = start;
    if (!seen_q[a] || roll >= 80 && roll < 86) begin
      s = $urandom;
    end else if (roll < 50) begin
      s = top_seq[a] + $urandom_range(span, 1);
    end else if (roll < 65) begin
      // aim at a marked hole when there is one
      for (int j = MAP_BITS - 1; j >= 0; j--) begin
        idx = (start + j) % MAP_BITS;
        if (gap_map[a][idx]) hit = idx;
      end
      s = top_seq[a] - 1 - hit;
    end else if (roll < 73) begin
      s = top_seq[a] + reanchor_dist + 1 + $urandom_range(1000);
    end else if (roll < 80) begin
      s = top_seq[a] - $urandom_range(300);
    end else begin
      s = top_seq[a] + $urandom_range(3, 1);
    end
    return s;
  endfunction

  // Present one transaction, wait for acceptance, then record what it should report.
  task automatic drive_item(input logic [pslt_pkg::KIND_W-1:0] k,
                            input logic [pslt_pkg::ADAPTER_W-1:0] a,
                            input logic [pslt_pkg::SEQ_W-1:0] s, input logic typed,
                            input tally_t typed_want);
    tally_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    adapter  <= a;
    seq      <= s;
    do @(posedge clk); while (!in_ready);
    pred = apply_packet(k, a, s);
    if (typed) pred = typed_want;
    tally_q = {tally_q, pred};
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tally_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reanchor(input logic [pslt_pkg::DIST_W-1:0] d);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reanchor_dist = d;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    tally_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tally_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result event %0d exp %0d rcv %0d",
                                event_res, expected_count, received_count));
      end else begin
        want = tally_q.pop_front();
        if (event_res !== want.ev)
          note_mismatch($sformatf("event %0d, want %0d", event_res, want.ev));
        if (expected_count !== want.expc)
          note_mismatch($sformatf("expected_count %0d, want %0d", expected_count, want.expc));
        if (received_count !== want.rcvc)
          note_mismatch($sformatf("received_count %0d, want %0d", received_count, want.rcvc));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_per_adapter_seq_loss_tracker: errors");
    $finish;
  end

  initial begin
    tally_t                         none;
    logic [pslt_pkg::KIND_W-1:0]    k;
    logic [pslt_pkg::ADAPTER_W-1:0] a;
    logic [pslt_pkg::SEQ_W-1:0]     s;
    none = '{pslt_pkg::EV_IGNORED, '0, '0};
    for (int i = 0; i < NUM_ADAPTERS; i++) begin
      seen_q[i]  = 1'b0;
      top_seq[i] = '0;
    end
    clear_stats();
    reanchor_dist = pslt_pkg::REANCHOR_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      drive_item(dir_rows[r].kind, dir_rows[r].adapter, dir_rows[r].seq,
                 dir_rows[r].typed, dir_rows[r].want);
    drop_valid();

    for (int p = 0; p < PHASES; p++) begin
      set_reanchor(phase_dist[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        a = $urandom_range(NUM_ADAPTERS - 1);
        k = ($urandom_range(149) == 0) ? pslt_pkg::KIND_CLEAR : KIND_NOTE;
        s = (k == pslt_pkg::KIND_CLEAR) ? $urandom : pick_seq(a);
        drive_item(k, a, s, 1'b0, none);
        // hold the sender until the output side has fully caught up
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          drop_valid();
          while (tally_q.size() != 0) @(posedge clk);
        end
      end
      drop_valid();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb_per_adapter_seq_loss_tracker: clean");
    else
      $display("tb_per_adapter_seq_loss_tracker: errors");
    $finish;
  end

endmodule
